// ===== design/seconds_calendar_clock_unit_assert.svh =====
// ----------------------------------------------------------------------------
// seconds calendar clock assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SECONDS_CALENDAR_CLOCK_UNIT_ASSERT_SVH
`define SECONDS_CALENDAR_CLOCK_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define SCC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SCC_ASSERT_SAME(label, ante, cons, msg)
`define SCC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== design/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// shared types, constants and the month offset table of the calendar clock
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_SET  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic [24:0] SECS_PER_YEAR = 25'd31536000;
	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
	localparam logic [6:0]  YEAR_MAX      = 7'd99;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] set_year;
		logic [3:0] set_month;
		logic [4:0] set_date;
		logic [4:0] set_hour;
		logic [5:0] set_minute;
		logic [5:0] set_second;
	} cmd_t;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] date;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} cal_t;

	// set value built from the item fields, year above 99 already forced to zero
	typedef struct packed {
		logic [1:0]  action;
		logic [24:0] sum;
		logic [6:0]  year;
	} load_t;

	// counter and year after the item took effect
	typedef struct packed {
		logic [24:0] sec;
		logic [6:0]  year;
	} stamp_t;

	// second of year at which month idx+1 starts
	function automatic logic [24:0] month_start(input logic [3:0] idx);
		logic [24:0] r;
		case (idx)
			4'd0:    r = 25'd0;
			4'd1:    r = 25'd2678400;
			4'd2:    r = 25'd5097600;
			4'd3:    r = 25'd7776000;
			4'd4:    r = 25'd10368000;
			4'd5:    r = 25'd13046400;
			4'd6:    r = 25'd15638400;
			4'd7:    r = 25'd18316800;
			4'd8:    r = 25'd20995200;
			4'd9:    r = 25'd23587200;
			4'd10:   r = 25'd26265600;
			4'd11:   r = 25'd28857600;
			default: r = 25'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/scc_load.sv =====
// ----------------------------------------------------------------------------
// scc_load
// input register: clamps the set fields and builds the set counter value
// ----------------------------------------------------------------------------
module scc_load
	import scc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	input  cmd_t  up_item,
	output logic  up_ready,
	output logic  dn_valid,
	output load_t dn_item,
	input  logic  dn_ready
);

	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

	logic        valid_s1;
	load_t       item_s1;
	logic [3:0]  m_idx;
	logic [4:0]  d_idx;
	load_t       item_d;

	always_comb begin
		if (up_item.set_month == 4'd0) begin
			m_idx = 4'd0;
		end else if (up_item.set_month > 4'd12) begin
			m_idx = 4'd11;
		end else begin
			m_idx = up_item.set_month - 4'd1;
		end
		d_idx = (up_item.set_date == 5'd0) ? 5'd0 : up_item.set_date - 5'd1;

		item_d.action = up_item.action;
		item_d.sum    = month_start(m_idx)
		              + 25'(d_idx) * 25'(SECS_PER_DAY)
		              + 25'(up_item.set_hour) * 25'(SECS_PER_HOUR)
		              + 25'(up_item.set_minute) * 25'(SECS_PER_MIN)
		              + 25'(up_item.set_second);
		item_d.year   = (up_item.set_year > 8'(YEAR_MAX)) ? 7'd0 : up_item.set_year[6:0];
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			item_s1 <= item_d;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_item  = item_s1;

endmodule

// ===== design/scc_state.sv =====
// ----------------------------------------------------------------------------
// scc_state
// second-of-year counter and year: applies tick or set, read and other actions hold, wraps at year end
// ----------------------------------------------------------------------------
`include "seconds_calendar_clock_unit_assert.svh"

module scc_state
	import scc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   up_valid,
	input  load_t  up_item,
	output logic   up_ready,
	output logic   dn_valid,
	output stamp_t dn_item,
	input  logic   dn_ready
);

	logic [24:0] sec_q;
	logic [6:0]  year_q;
	logic        valid_s2;
	stamp_t      item_s2;
	logic [24:0] base_sec;
	logic [6:0]  base_year;
	logic [24:0] sec_n;
	logic [6:0]  year_n;
	logic        take;

	function automatic logic [6:0] next_year(input logic [6:0] y);
		logic [6:0] yn;
		yn = y + 7'd1;
		return (yn > YEAR_MAX) ? 7'd0 : yn;
	endfunction

	always_comb begin
		case (up_item.action)
			ACT_TICK: begin
				base_sec  = sec_q + 25'd1;
				base_year = year_q;
			end
			ACT_SET: begin
				base_sec  = up_item.sum;
				base_year = up_item.year;
			end
			ACT_READ: begin
				base_sec  = sec_q;
				base_year = year_q;
			end
			default: begin
				base_sec  = sec_q;
				base_year = year_q;
			end
		endcase
		if (base_sec >= SECS_PER_YEAR) begin
			sec_n  = base_sec - SECS_PER_YEAR;
			year_n = next_year(base_year);
		end else begin
			sec_n  = base_sec;
			year_n = base_year;
		end
	end

	assign up_ready = !valid_s2 || dn_ready;
	assign take     = up_valid && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q    <= 25'd0;
			year_q   <= 7'd0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				sec_q  <= sec_n;
				year_q <= year_n;
			end
			if (up_ready) begin
				valid_s2 <= up_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s2.sec  <= sec_n;
			item_s2.year <= year_n;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_item  = item_s2;

	`SCC_ASSERT_SAME(a_sec_range, 1'b1, sec_q < SECS_PER_YEAR, "counter past year end")
	`SCC_ASSERT_SAME(a_year_range, 1'b1, year_q <= YEAR_MAX, "year above limit")
	`SCC_ASSERT_NEXT(a_tick_step, take && up_item.action == ACT_TICK && sec_q != SECS_PER_YEAR - 25'd1, sec_q == $past(sec_q) + 25'd1 && $stable(year_q), "tick did not add one second")
	`SCC_ASSERT_NEXT(a_hold, !take, $stable(sec_q) && $stable(year_q), "state changed without an item")

endmodule

// ===== design/scc_split.sv =====
// ----------------------------------------------------------------------------
// scc_split
// breakdown pipeline: month search, day, then hour, minute and second
// ----------------------------------------------------------------------------
module scc_split
	import scc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   up_valid,
	input  stamp_t up_item,
	output logic   up_ready,
	output logic   dn_valid,
	output cal_t   dn_item,
	input  logic   dn_ready
);

	// floor(x / d) = (x * recip) >> shift, exact over the ranges used here
	localparam logic [14:0] DAY_RECIP   = 15'd24856;
	localparam logic [12:0] HOUR_RECIP  = 13'd4661;
	localparam logic [15:0] MIN_RECIP   = 16'd34953;
	localparam logic [5:0]  MIN_PER_HOUR = 6'd60;

	logic valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;

	logic [6:0]  year_s3, year_s4, year_s5, year_s6;
	logic [3:0]  month_s3, month_s4, month_s5, month_s6;
	logic [21:0] rem_s3, rem_s4;
	logic [4:0]  dq_s4;
	logic [4:0]  date_s5, date_s6;
	logic [16:0] sod_s5, sod_s6;
	logic [4:0]  hq_s6;
	logic [10:0] tm_s6;
	cal_t        item_s7;

	logic [10:0] thermo;
	logic [3:0]  mcnt;
	logic [29:0] day_prod;
	logic [25:0] hour_prod;
	logic [30:0] min_prod;

	assign rdy_s7   = !valid_s7 || dn_ready;
	assign rdy_s6   = !valid_s6 || rdy_s7;
	assign rdy_s5   = !valid_s5 || rdy_s6;
	assign rdy_s4   = !valid_s4 || rdy_s5;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign up_ready = rdy_s3;

	always_comb begin
		for (int k = 1; k < 12; k++) begin
			thermo[k-1] = up_item.sec >= month_start(4'(k));
		end
		mcnt      = 4'($countones(thermo));
		day_prod  = 30'(rem_s3[21:7]) * 30'(DAY_RECIP);
		hour_prod = 26'(sod_s5[16:4]) * 26'(HOUR_RECIP);
		min_prod  = 31'(sod_s5[16:2]) * 31'(MIN_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (rdy_s3) valid_s3 <= up_valid;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_s5) valid_s5 <= valid_s4;
			if (rdy_s6) valid_s6 <= valid_s5;
			if (rdy_s7) valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && up_valid) begin
			year_s3  <= up_item.year;
			month_s3 <= mcnt + 4'd1;
			rem_s3   <= 22'(up_item.sec - month_start(mcnt));
		end
		if (rdy_s4 && valid_s3) begin
			year_s4  <= year_s3;
			month_s4 <= month_s3;
			rem_s4   <= rem_s3;
			dq_s4    <= day_prod[28:24];
		end
		if (rdy_s5 && valid_s4) begin
			year_s5  <= year_s4;
			month_s5 <= month_s4;
			date_s5  <= dq_s4 + 5'd1;
			sod_s5   <= 17'(rem_s4 - 22'(dq_s4) * 22'(SECS_PER_DAY));
		end
		if (rdy_s6 && valid_s5) begin
			year_s6  <= year_s5;
			month_s6 <= month_s5;
			date_s6  <= date_s5;
			sod_s6   <= sod_s5;
			hq_s6    <= hour_prod[24:20];
			tm_s6    <= min_prod[29:19];
		end
		if (rdy_s7 && valid_s6) begin
			item_s7.year   <= year_s6;
			item_s7.month  <= month_s6;
			item_s7.date   <= date_s6;
			item_s7.hour   <= hq_s6;
			item_s7.minute <= 6'(tm_s6 - 11'(hq_s6) * 11'(MIN_PER_HOUR));
			item_s7.second <= 6'(sod_s6 - 17'(tm_s6) * 17'(SECS_PER_MIN));
		end
	end

	assign dn_valid = valid_s7;
	assign dn_item  = item_s7;

endmodule

// ===== design/seconds_calendar_clock_unit.sv =====
// throughput: one item per cycle while cal_stall is low, the counter update is registered directly
// the breakdown pipeline uses reciprocal multiplies in place of divides
// stages advance independently, so bubbles fill while a result is stalled
// reset: counter and year clear to zero, all stages empty
// ----------------------------------------------------------------------------
// seconds_calendar_clock_unit
// calendar clock with a second-of-year counter, two-digit year, no leap years
// ----------------------------------------------------------------------------
module seconds_calendar_clock_unit
	import scc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic cal_valid,
	input  logic cal_stall,
	output cal_t cal
);

	logic   load_ready;
	logic   load_valid;
	load_t  load_item;
	logic   state_ready;
	logic   stamp_valid;
	stamp_t stamp_item;
	logic   split_ready;

	scc_load u_load (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cmd_valid),
		.up_item  (cmd),
		.up_ready (load_ready),
		.dn_valid (load_valid),
		.dn_item  (load_item),
		.dn_ready (state_ready)
	);

	scc_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (load_valid),
		.up_item  (load_item),
		.up_ready (state_ready),
		.dn_valid (stamp_valid),
		.dn_item  (stamp_item),
		.dn_ready (split_ready)
	);

	scc_split u_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (stamp_valid),
		.up_item  (stamp_item),
		.up_ready (split_ready),
		.dn_valid (cal_valid),
		.dn_item  (cal),
		.dn_ready (!cal_stall)
	);

	assign cmd_stall = !load_ready;

endmodule

// ===== bench/seconds_calendar_clock_unit_test.sv =====
// ----------------------------------------------------------------------------
// seconds_calendar_clock_unit_test
// self-checking bench for the calendar clock: drives tick, set, read and
// undefined actions with random idle and stall bursts, predicts the broken
// down time of every item and compares each result field by field
// ----------------------------------------------------------------------------
module seconds_calendar_clock_unit_test;
	import scc_pkg::*;

	localparam int unsigned SEC_YEAR    = 31536000;
	localparam int unsigned SEC_DAY     = 86400;
	localparam int unsigned SEC_HOUR    = 3600;
	localparam int unsigned YEAR_TOP    = 99;
	localparam logic [1:0]  ACT_UNDEF   = 2'd3;
	localparam int          ITEMS       = 1300;
	localparam int          CALM_TAIL   = 200;
	localparam int          QUIET_LIMIT = 2000;
	localparam int          DRAIN_WAIT  = 12;

	class calendar_board;
		bit [24:0] sec_of_year;
		bit [6:0]  year_now;
		cal_t      due_q[$];
		int        errors;

		function int month_days(int m);
			case (m)
				2: return 28;
				4, 6, 9, 11: return 30;
				default: return 31;
			endcase
		endfunction

		function void note_cmd(cmd_t c);
			int unsigned total, m, d, days, rem;
			int k;
			cal_t r;
			case (c.action)
				ACT_TICK: sec_of_year = sec_of_year + 25'd1;
				ACT_SET: begin
					m = (c.set_month == 0) ? 1 : ((c.set_month > 12) ? 12 : c.set_month);
					d = (c.set_date == 0) ? 1 : c.set_date;
					year_now = (c.set_year > YEAR_TOP) ? 7'd0 : c.set_year[6:0];
					total = c.set_second + c.set_minute * 60 + c.set_hour * SEC_HOUR
						+ (d - 1) * SEC_DAY;
					for (k = 1; k < m; k++)
						total += month_days(k) * SEC_DAY;
					sec_of_year = total[24:0];
				end
				default: ;
			endcase
			if (sec_of_year >= SEC_YEAR) begin
				sec_of_year = 25'(sec_of_year - SEC_YEAR);
				year_now = (year_now >= YEAR_TOP) ? 7'd0 : year_now + 7'd1;
			end
			days = sec_of_year / SEC_DAY;
			rem = sec_of_year % SEC_DAY;
			m = 1;
			while (days >= month_days(m)) begin
				days -= month_days(m);
				m++;
			end
			r.year = year_now;
			r.month = 4'(m);
			r.date = 5'(days + 1);
			r.hour = 5'(rem / SEC_HOUR);
			r.minute = 6'((rem % SEC_HOUR) / 60);
			r.second = 6'(rem % 60);
			due_q.push_back(r);
		endfunction

		function void compare(string name, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_cal(cal_t got);
			cal_t want;
			if (due_q.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
				return;
			end
			want = due_q.pop_front();
			compare("year", want.year, got.year);
			compare("month", want.month, got.month);
			compare("date", want.date, got.date);
			compare("hour", want.hour, got.hour);
			compare("minute", want.minute, got.minute);
			compare("second", want.second, got.second);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic cal_valid;
	logic cal_stall;
	cal_t cal;

	calendar_board board;
	bit idle_on;
	bit stall_on;
	int n_sent;
	int quiet_cycles;

	seconds_calendar_clock_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.cal_valid(cal_valid),
		.cal_stall(cal_stall),
		.cal(cal)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				board.note_cmd(cmd);
			if (cal_valid && !cal_stall)
				board.check_cal(cal);
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (cal_valid && !cal_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// result side stall bursts
	initial begin
		int burst;
		burst = 0;
		cal_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_on && burst == 0 && $urandom_range(0, 5) == 0)
				burst = $urandom_range(1, 12);
			if (burst > 0) begin
				cal_stall <= 1'b1;
				burst--;
			end else begin
				cal_stall <= 1'b0;
			end
		end
	end

	function automatic cmd_t make_cmd(logic [1:0] a, int y, int mo, int d, int h, int mi,
		int s);
		cmd_t c;
		c.action = a;
		c.set_year = 8'(y);
		c.set_month = 4'(mo);
		c.set_date = 5'(d);
		c.set_hour = 5'(h);
		c.set_minute = 6'(mi);
		c.set_second = 6'(s);
		return c;
	endfunction

	function automatic cmd_t rand_cmd(logic [1:0] a);
		return make_cmd(a, $urandom_range(0, 255), $urandom_range(0, 15),
			$urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 63),
			$urandom_range(0, 63));
	endfunction

	// called and returns at a falling edge
	task automatic send_cmd(cmd_t c);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (cmd_stall);
		n_sent++;
		@(negedge clk);
	endtask

	initial begin
		int mo, pick;
		board = new();
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		idle_on = 1'b0;
		stall_on = 1'b0;
		n_sent = 0;
		quiet_cycles = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed items
		send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_TICK, 255, 15, 31, 31, 63, 63));
		send_cmd(make_cmd(ACT_UNDEF, 255, 15, 31, 31, 63, 63));
		send_cmd(make_cmd(ACT_SET, 99, 12, 31, 23, 59, 59));
		send_cmd(make_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_SET, 255, 15, 31, 31, 63, 63));
		send_cmd(make_cmd(ACT_SET, 100, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_SET, 99, 13, 31, 31, 63, 63));
		send_cmd(make_cmd(ACT_SET, 98, 2, 28, 23, 59, 59));
		send_cmd(make_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_SET, 0, 1, 31, 23, 59, 59));
		send_cmd(make_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_SET, 127, 8, 16, 16, 32, 32));
		send_cmd(make_cmd(ACT_SET, 42, 4, 30, 22, 59, 59));
		send_cmd(make_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_SET, 7, 6, 15, 10, 58, 59));
		send_cmd(make_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_UNDEF, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(ACT_SET, 1, 1, 1, 0, 0, 0));

		// random part
		while (n_sent < ITEMS) begin
			idle_on = (n_sent < ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
			stall_on = (n_sent < ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				// land just short of a rollover, then tick across it
				mo = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 12);
				send_cmd(make_cmd(ACT_SET,
					($urandom_range(0, 5) == 0) ? 99 : $urandom_range(0, 99), mo,
					$urandom_range(0, 1) ? board.month_days(mo)
						: $urandom_range(1, board.month_days(mo)),
					$urandom_range(0, 1) ? 23 : $urandom_range(0, 23),
					$urandom_range(0, 1) ? 59 : $urandom_range(0, 59),
					$urandom_range(48, 59)));
				repeat ($urandom_range(1, 14))
					send_cmd(rand_cmd(($urandom_range(0, 4) == 0) ? ACT_READ : ACT_TICK));
			end else if (pick < 70) begin
				send_cmd(rand_cmd(ACT_SET));
			end else if (pick < 85) begin
				send_cmd(make_cmd(ACT_SET, $urandom_range(0, 99), $urandom_range(1, 12),
					$urandom_range(1, 28), $urandom_range(0, 23), $urandom_range(0, 59),
					$urandom_range(0, 59)));
			end else begin
				send_cmd(rand_cmd(2'($urandom_range(0, 3))));
			end
		end
		idle_on = 1'b0;
		stall_on = 1'b0;
		cmd_valid <= 1'b0;

		while (board.due_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
